FILE: src/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// Shared constants, codes and types for the S-curve speed ramp.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_RUN  = 2'd2;
  localparam logic [1:0] OP_STOP = 2'd3;

  localparam logic [1:0] CFG_ACCEL = 2'd0;
  localparam logic [1:0] CFG_VMAX  = 2'd1;
  localparam logic [1:0] CFG_VMIN  = 2'd2;
  localparam logic [1:0] CFG_SCALE = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_TWO  = 2'd2;

  localparam logic MODE_DIV  = 1'b0;
  localparam logic MODE_SQRT = 1'b1;

  localparam logic [31:0] ONE_TENTH   = 32'd6554;
  localparam logic [31:0] HALF_MS     = 32'd32768;
  localparam logic [31:0] MAX32       = 32'hFFFF_FFFF;
  localparam logic [63:0] MAX64       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;

  localparam logic [31:0] RST_ACCEL = 32'd65536;
  localparam logic [31:0] RST_VMAX  = 32'd6553600;
  localparam logic [31:0] RST_VMIN  = 32'd6554;
  localparam logic [31:0] RST_SCALE = 32'd1000000;

  typedef struct packed {
    logic        start;
    logic        mode;
    logic [6:0]  cnt;
    logic [63:0] num;
    logic [31:0] den;
  } scr_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } scr_rsp_t;

  function automatic logic [63:0] add_sat(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[64] ? MAX64 : s[63:0];
  endfunction

endpackage

FILE: src/scr_iter.sv
// ----------------------------------------------------------------------------
// scr_iter
// Shared bit-serial unit: restoring divide (one quotient bit a cycle) or
// integer square root (one root bit a cycle). Numerator is left-aligned.
// ----------------------------------------------------------------------------
module scr_iter import scr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  scr_req_t req,
  output scr_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic        mode_r;
  logic [6:0]  cnt_r;
  logic [63:0] num_r;
  logic [31:0] den_r;
  logic [35:0] rem_r;
  logic [63:0] res_r;

  logic [35:0] rem_ext;
  logic [35:0] trial;
  logic        take;
  logic [35:0] rem_nxt;

  always_comb begin
    if (mode_r == MODE_SQRT) begin
      rem_ext = {rem_r[33:0], num_r[63:62]};
      trial   = {2'b00, res_r[31:0], 2'b01};
    end else begin
      rem_ext = {rem_r[34:0], num_r[63]};
      trial   = {4'b0000, den_r};
    end
    take    = (rem_ext >= trial);
    rem_nxt = take ? (rem_ext - trial) : rem_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        mode_r <= req.mode;
        cnt_r  <= req.cnt;
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        res_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        res_r <= {res_r[62:0], take};
        num_r <= (mode_r == MODE_SQRT) ? {num_r[61:0], 2'b00} : {num_r[62:0], 1'b0};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

FILE: src/s_curve_speed_ramp.sv
// ----------------------------------------------------------------------------
// s_curve_speed_ramp
// Stepper S-curve speed ramp: plans a ramp on an idle set-speed, evaluates the
// speed and timer prescaler on each tick of a running ramp, one shared 32x32
// multiplier and one bit-serial divide/square-root unit under a sequencer.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  in_      | in_valid/in_stall  | in_opcode, in_speed_command
//  out_     | out_valid/out_stall| out_prescaler, out_output_enable,
//           |                    | out_ramp_active, out_speed_now
//  cfg_     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item at a time; in_stall is high from acceptance until its result is
//  loaded into the output register. Run, stop and idle items go straight to
//  the output; a ramp tick runs the multiplies and a 48-step prescaler divide;
//  a set-speed runs up to a 64-step divide, a 32-step root and a 34-step divide.
//  Reset is synchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
module s_curve_speed_ramp import scr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_speed_command,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_prescaler,
  output logic        out_output_enable,
  output logic        out_ramp_active,
  output logic [31:0] out_speed_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SW   = 5'd1;
  localparam logic [4:0] S_SC   = 5'd2;
  localparam logic [4:0] S_QD   = 5'd3;
  localparam logic [4:0] S_SQ   = 5'd4;
  localparam logic [4:0] S_STD  = 5'd5;
  localparam logic [4:0] S_M0   = 5'd6;
  localparam logic [4:0] S_M1   = 5'd7;
  localparam logic [4:0] S_M2   = 5'd8;
  localparam logic [4:0] S_M3   = 5'd9;
  localparam logic [4:0] S_M4   = 5'd10;
  localparam logic [4:0] S_M5   = 5'd11;
  localparam logic [4:0] S_SP   = 5'd12;
  localparam logic [4:0] S_SV   = 5'd13;
  localparam logic [4:0] S_PD   = 5'd14;
  localparam logic [4:0] S_FIN  = 5'd15;
  localparam logic [4:0] S_DONE = 5'd16;

  logic [31:0] accel_r, vmax_r, vmin_r, scale_r;
  logic [31:0] cur_r, start_r, tgt_r, mid_r, infl_r, step_r, elap_r;
  logic [1:0]  phase_r;
  logic        dec_r, en_r, comp_r;
  logic [15:0] presc_r;
  logic [4:0]  state_r;
  logic [31:0] cmd_r;
  logic [63:0] prod_r, p_r, h_r, x_r, y_r;
  logic [95:0] acc_r;
  logic [31:0] v_r;
  logic        out_valid_r;
  logic [15:0] out_presc_r;
  logic        out_en_r, out_act_r;
  logic [31:0] out_speed_r;

  logic [31:0] a_eff;
  logic [31:0] mul_x, mul_y;
  scr_req_t    req;
  scr_rsp_t    rsp;

  logic [32:0] t_sum;
  logic [31:0] t_nxt;
  logic [31:0] wanted;
  logic        sc_dec;
  logic [31:0] sc_t;
  logic        sc_wrong;
  logic [32:0] sc_sum;
  logic [31:0] sc_mid;
  logic [31:0] sc_dv;
  logic [31:0] sc_n;
  logic [31:0] step_v;
  logic [32:0] step_sum;
  logic [63:0] w_val, s3, m2;
  logic [63:0] xa, xb, ya, yb;
  logic [63:0] d_val;
  logic [31:0] v_nxt;
  logic [63:0] q_pre;
  logic [15:0] presc_nxt;
  logic [1:0]  ph_tmp;
  logic        near;
  logic        ramp_end;
  logic        out_load;

  scr_iter u_iter (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  assign a_eff     = (accel_r != 32'd0) ? accel_r : 32'd1;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_prescaler     = out_presc_r;
  assign out_output_enable = out_en_r;
  assign out_ramp_active   = out_act_r;
  assign out_speed_now     = out_speed_r;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // tick time
  assign t_sum = {1'b0, elap_r} + {1'b0, step_r};
  assign t_nxt = t_sum[32] ? MAX32 : t_sum[31:0];

  // set-speed planning
  always_comb begin
    wanted   = {3'b000, prod_r[63:35]};
    sc_dec   = !(cur_r < wanted);
    if (!sc_dec) sc_t = (wanted < vmax_r) ? wanted : vmax_r;
    else sc_t = (wanted > vmin_r) ? wanted : vmin_r;
    sc_wrong = (!sc_dec && sc_t <= cur_r) || (sc_dec && sc_t >= cur_r);
    sc_sum   = {1'b0, sc_t} + {1'b0, cur_r};
    sc_mid   = sc_sum[32:1];
    sc_dv    = sc_dec ? (sc_mid - sc_t) : (sc_mid - cur_r);
    sc_n     = {sc_dv[30:0], 1'b0};
    step_v   = dec_r ? tgt_r : cur_r;
    step_sum = {1'b0, rsp.res[31:0]} + {1'b0, HALF_MS};
  end

  // shared multiplier operands
  always_comb begin
    case (state_r)
      S_SW: begin mul_x = cmd_r;        mul_y = RECIP_TEN; end
      S_M0: begin mul_x = a_eff;        mul_y = elap_r;    end
      S_M1: begin mul_x = prod_r[31:0]; mul_y = elap_r;    end
      S_M2: begin mul_x = p_r[63:32];   mul_y = elap_r;    end
      S_M3: begin mul_x = p_r[31:0];    mul_y = infl_r;    end
      S_M4: begin mul_x = p_r[63:32];   mul_y = infl_r;    end
      default: begin mul_x = '0;        mul_y = '0;        end
    endcase
  end

  // speed formula
  always_comb begin
    w_val = acc_r[95] ? MAX64 : acc_r[94:31];
    s3    = {30'd0, ({2'b00, start_r} + {1'b0, start_r, 1'b0})};
    m2    = {31'd0, mid_r, 1'b0};
    xa = '0; xb = '0; ya = '0; yb = '0;
    if (!dec_r) begin
      if (phase_r == PH_ONE) begin
        xa = {32'd0, start_r}; xb = h_r;
      end else begin
        xa = w_val; xb = s3; ya = h_r; yb = m2;
      end
    end else begin
      if (phase_r == PH_ONE) begin
        xa = {32'd0, start_r}; ya = h_r;
      end else begin
        xa = h_r; xb = s3; ya = w_val; yb = m2;
      end
    end
    d_val = x_r - y_r;
    if (x_r <= y_r) v_nxt = '0;
    else if (d_val[63:32] != 32'd0) v_nxt = MAX32;
    else v_nxt = d_val[31:0];
    q_pre = rsp.res - 64'd1;
    if (rsp.res == 64'd0) presc_nxt = '0;
    else if (q_pre[63:16] != 48'd0) presc_nxt = 16'hFFFF;
    else presc_nxt = q_pre[15:0];
  end

  // phase change and ramp end
  always_comb begin
    ph_tmp = (phase_r == PH_ONE && elap_r >= infl_r) ? PH_TWO : phase_r;
    if (!dec_r) near = (v_r >= tgt_r) || ((tgt_r - v_r) <= ONE_TENTH);
    else near = (v_r <= tgt_r) || ((v_r - tgt_r) <= ONE_TENTH);
    ramp_end = (ph_tmp == PH_TWO) &&
               (near || ({1'b0, elap_r} >= {infl_r, 1'b0}) || (elap_r == MAX32));
  end

  // requests to the shared divide/root unit
  always_comb begin
    req = '0;
    case (state_r)
      S_SC: begin
        if (wanted != cur_r && !sc_wrong) begin
          req.start = 1'b1; req.mode = MODE_DIV; req.cnt = 7'd64;
          req.num = {sc_n, 32'd0}; req.den = a_eff;
        end
      end
      S_QD: begin
        if (rsp.done) begin
          req.start = 1'b1; req.mode = MODE_SQRT; req.cnt = 7'd32;
          req.num = rsp.res;
        end
      end
      S_SQ: begin
        if (rsp.done && rsp.res[31:0] != 32'd0 && step_v != 32'd0) begin
          req.start = 1'b1; req.mode = MODE_DIV; req.cnt = 7'd34;
          req.num = {1'b1, 63'd0}; req.den = step_v;
        end
      end
      S_SV: begin
        if (v_nxt != 32'd0) begin
          req.start = 1'b1; req.mode = MODE_DIV; req.cnt = 7'd48;
          req.num = {scale_r, 32'd0}; req.den = v_nxt;
        end
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_x * mul_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= RST_ACCEL;
      vmax_r  <= RST_VMAX;
      vmin_r  <= RST_VMIN;
      scale_r <= RST_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACCEL: accel_r <= cfg_data;
        CFG_VMAX:  vmax_r  <= cfg_data;
        CFG_VMIN:  vmin_r  <= cfg_data;
        CFG_SCALE: scale_r <= cfg_data;
        default:   accel_r <= accel_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= ONE_TENTH;
      start_r     <= '0;
      tgt_r       <= '0;
      mid_r       <= '0;
      infl_r      <= '0;
      step_r      <= '0;
      elap_r      <= '0;
      phase_r     <= PH_IDLE;
      dec_r       <= 1'b0;
      en_r        <= 1'b0;
      presc_r     <= '0;
      comp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r  <= in_speed_command;
            comp_r <= 1'b0;
            case (in_opcode)
              OP_TICK: begin
                if (phase_r != PH_IDLE) begin
                  elap_r  <= t_nxt;
                  state_r <= S_M0;
                end else begin
                  state_r <= S_DONE;
                end
              end
              OP_SET: state_r <= (phase_r != PH_IDLE) ? S_DONE : S_SW;
              default: begin
                en_r    <= (in_opcode == OP_RUN);
                cur_r   <= ONE_TENTH;
                phase_r <= PH_IDLE;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_SW: state_r <= S_SC;
        S_SC: begin
          if (wanted == cur_r) begin
            state_r <= S_DONE;
          end else if (sc_wrong) begin
            cur_r   <= sc_t;
            state_r <= S_DONE;
          end else begin
            tgt_r   <= sc_t;
            mid_r   <= sc_mid;
            dec_r   <= sc_dec;
            state_r <= S_QD;
          end
        end
        S_QD: if (rsp.done) state_r <= S_SQ;
        S_SQ: begin
          if (rsp.done) begin
            infl_r <= rsp.res[31:0];
            if (rsp.res[31:0] == 32'd0) begin
              cur_r   <= tgt_r;
              state_r <= S_DONE;
            end else if (step_v == 32'd0) begin
              step_r  <= MAX32;
              start_r <= cur_r;
              elap_r  <= '0;
              phase_r <= PH_ONE;
              state_r <= S_DONE;
            end else begin
              state_r <= S_STD;
            end
          end
        end
        S_STD: begin
          if (rsp.done) begin
            step_r  <= (rsp.res[63:32] != 32'd0 || step_sum[32]) ? MAX32 : step_sum[31:0];
            start_r <= cur_r;
            elap_r  <= '0;
            phase_r <= PH_ONE;
            state_r <= S_DONE;
          end
        end
        S_M0: state_r <= S_M1;
        S_M1: begin
          p_r     <= prod_r;
          state_r <= S_M2;
        end
        S_M2: begin
          acc_r   <= {32'd0, prod_r};
          state_r <= S_M3;
        end
        S_M3: begin
          acc_r   <= acc_r + {prod_r, 32'd0};
          state_r <= S_M4;
        end
        S_M4: begin
          h_r     <= {1'b0, acc_r[95:33]};
          acc_r   <= {32'd0, prod_r};
          state_r <= S_M5;
        end
        S_M5: begin
          acc_r   <= acc_r + {prod_r, 32'd0};
          state_r <= S_SP;
        end
        S_SP: begin
          x_r     <= add_sat(xa, xb);
          y_r     <= add_sat(ya, yb);
          state_r <= S_SV;
        end
        S_SV: begin
          v_r <= v_nxt;
          if (v_nxt == 32'd0) begin
            presc_r <= 16'hFFFF;
            state_r <= S_FIN;
          end else begin
            state_r <= S_PD;
          end
        end
        S_PD: begin
          if (rsp.done) begin
            presc_r <= presc_nxt;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          comp_r <= 1'b1;
          if (ramp_end) begin
            cur_r   <= tgt_r;
            phase_r <= PH_IDLE;
          end else begin
            phase_r <= ph_tmp;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_presc_r <= presc_r;
      out_en_r    <= en_r;
      out_act_r   <= (phase_r != PH_IDLE);
      out_speed_r <= comp_r ? v_r : cur_r;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("item accepted but sequencer stayed idle");

  a_ramp_infl: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (infl_r != 32'd0))
    else $error("ramp running with zero inflection time");

  a_iter_done: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == S_QD || state_r == S_SQ || state_r == S_STD ||
                  state_r == S_PD))
    else $error("iterative unit finished outside a wait state");

endmodule
